// File: hdl/bfie_pkg.sv
// shared types, constants and symbol codes for the tape-language executor
package bfie_pkg;

   localparam int MEM_DEPTH  = 4096;
   localparam int CODE_DEPTH = 4096;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int CODE_AW    = $clog2(CODE_DEPTH);

   localparam logic [7:0] SYM_INC  = 8'h2B;  // '+'
   localparam logic [7:0] SYM_DEC  = 8'h2D;  // '-'
   localparam logic [7:0] SYM_NEXT = 8'h3E;  // '>'
   localparam logic [7:0] SYM_PREV = 8'h3C;  // '<'
   localparam logic [7:0] SYM_OUT  = 8'h2E;  // '.'
   localparam logic [7:0] SYM_IN   = 8'h2C;  // ','
   localparam logic [7:0] SYM_LOOP = 8'h5B;  // '['
   localparam logic [7:0] SYM_BACK = 8'h5D;  // ']'

   typedef logic [MEM_AW-1:0]  mem_addr_type;
   typedef logic [CODE_AW-1:0] code_addr_type;

   typedef enum logic [1:0] {
      SCAN_NONE  = 2'd0,
      SCAN_LEFT  = 2'd1,
      SCAN_RIGHT = 2'd2
   } scan_dir_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [11:0] next_code_addr;
      logic        out_valid;
      logic [7:0]  out_byte;
      logic        in_taken;
      logic [31:0] step_count;
   } rsp_type;

   // operation on the data tape for one executed request
   typedef struct packed {
      logic       move_up;
      logic       move_down;
      logic       write_en;
      logic [7:0] wdata;
   } tape_op_type;

endpackage

// File: hdl/bf_instruction_executor_unit.sv
// top level of the tape-language executor: decode, pointers, scan and handshakes
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  req_data  (symbol, in_byte)
//   rsp_     out        rsp_valid / rsp_ready  rsp_data  (next_code_addr, out_valid,
//                                                         out_byte, in_taken, step_count)
//
// one request per cycle sustained while rsp_ready stays high; a response is registered
// through the input register, then one decode and cell update pass into the result register
// the current cell lives in a register window fed by one memory read per pointer move
// after reset a clearing pass zeroes all MEM_DEPTH (4096) cells of the memory, with
// req_ready held low until it ends
// with rsp_ready low the result holds; req_ready drops once the input register is full
module bf_instruction_executor_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfie_pkg::rsp_type rsp_data
);

   localparam bfie_pkg::code_addr_type CODE_LAST =
      bfie_pkg::CODE_AW'(bfie_pkg::CODE_DEPTH - 1);

   logic                   in_vld_ff, in_vld_in;
   bfie_pkg::req_type      in_ff, in_in;
   logic                   out_vld_ff, out_vld_in;
   bfie_pkg::rsp_type      rsp_ff, rsp_in;
   bfie_pkg::code_addr_type cp_ff, cp_in;
   bfie_pkg::scan_dir_type dir_ff, dir_in;
   logic [11:0]            nest_ff, nest_in;
   logic [31:0]            steps_ff, steps_in;

   bfie_pkg::tape_op_type  op_raw, op;
   logic [7:0]             cur_cell;
   logic                   busy;
   logic                   exec;
   logic                   ov, it;
   logic [7:0]             ob;
   logic [7:0]             sym;

   bfie_tape u_tape (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .cur_cell (cur_cell),
      .busy     (busy)
   );

   assign exec      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !busy && (!in_vld_ff || exec);
   assign sym       = in_ff.symbol;

   always_comb begin
      dir_in = dir_ff;
      nest_in = nest_ff;
      op_raw = '0;
      ov = 1'b0;
      ob = 8'd0;
      it = 1'b0;
      case (dir_ff)
         bfie_pkg::SCAN_LEFT: begin
            if (sym == bfie_pkg::SYM_BACK) begin
               nest_in = nest_ff + 12'd1;
            end else if (sym == bfie_pkg::SYM_LOOP) begin
               if (nest_ff == 12'd0) begin
                  dir_in = bfie_pkg::SCAN_NONE;
               end else begin
                  nest_in = nest_ff - 12'd1;
               end
            end
         end
         bfie_pkg::SCAN_RIGHT: begin
            if (sym == bfie_pkg::SYM_LOOP) begin
               nest_in = nest_ff + 12'd1;
            end else if (sym == bfie_pkg::SYM_BACK) begin
               if (nest_ff == 12'd0) begin
                  dir_in = bfie_pkg::SCAN_NONE;
               end else begin
                  nest_in = nest_ff - 12'd1;
               end
            end
         end
         default: begin
            case (sym)
               bfie_pkg::SYM_INC: begin
                  op_raw.write_en = 1'b1;
                  op_raw.wdata    = cur_cell + 8'd1;
               end
               bfie_pkg::SYM_DEC: begin
                  op_raw.write_en = 1'b1;
                  op_raw.wdata    = cur_cell - 8'd1;
               end
               bfie_pkg::SYM_NEXT: op_raw.move_up = 1'b1;
               bfie_pkg::SYM_PREV: op_raw.move_down = 1'b1;
               bfie_pkg::SYM_OUT: begin
                  ov = 1'b1;
                  ob = cur_cell;
               end
               bfie_pkg::SYM_IN: begin
                  op_raw.write_en = 1'b1;
                  op_raw.wdata    = in_ff.in_byte;
                  it              = 1'b1;
               end
               bfie_pkg::SYM_BACK: begin
                  if (cur_cell != 8'd0) begin
                     dir_in = bfie_pkg::SCAN_LEFT;
                  end
               end
               bfie_pkg::SYM_LOOP: begin
                  if (cur_cell == 8'd0) begin
                     dir_in = bfie_pkg::SCAN_RIGHT;
                  end
               end
               default: ;
            endcase
         end
      endcase

      // code pointer moves after the direction update of this symbol
      if (dir_in == bfie_pkg::SCAN_LEFT) begin
         cp_in = (cp_ff == '0) ? CODE_LAST : cp_ff - 1'b1;
      end else begin
         cp_in = (cp_ff == CODE_LAST) ? '0 : cp_ff + 1'b1;
      end
      steps_in = steps_ff + 32'd1;

      rsp_in.next_code_addr = 12'(cp_in);
      rsp_in.out_valid      = ov;
      rsp_in.out_byte       = ob;
      rsp_in.in_taken       = it;
      rsp_in.step_count     = steps_in;

      op = exec ? op_raw : '0;

      in_vld_in  = in_vld_ff;
      in_in      = in_ff;
      out_vld_in = out_vld_ff;
      if (exec) begin
         in_vld_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
         in_in     = req_data;
      end
      if (rsp_valid && rsp_ready) begin
         out_vld_in = 1'b0;
      end
      if (exec) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         cp_ff      <= '0;
         dir_ff     <= bfie_pkg::SCAN_NONE;
         nest_ff    <= 12'd0;
         steps_ff   <= 32'd0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (exec) begin
            cp_ff    <= cp_in;
            dir_ff   <= dir_in;
            nest_ff  <= nest_in;
            steps_ff <= steps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/bfie_tape.sv
// data tape: cell memory with a register window around the data pointer
module bfie_tape (
   input  logic                  clock,
   input  logic                  reset,
   input  bfie_pkg::tape_op_type op,
   output logic [7:0]            cur_cell,
   output logic                  busy
);

   localparam logic [bfie_pkg::MEM_AW:0] DEPTH_W =
      (bfie_pkg::MEM_AW + 1)'(bfie_pkg::MEM_DEPTH);
   localparam bfie_pkg::mem_addr_type LAST_ADDR =
      bfie_pkg::MEM_AW'(bfie_pkg::MEM_DEPTH - 1);

   function automatic bfie_pkg::mem_addr_type addr_up(bfie_pkg::mem_addr_type a,
                                                      bfie_pkg::mem_addr_type k);
      logic [bfie_pkg::MEM_AW:0] sum;
      sum = {1'b0, a} + {1'b0, k};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[bfie_pkg::MEM_AW-1:0];
   endfunction

   function automatic bfie_pkg::mem_addr_type addr_down(bfie_pkg::mem_addr_type a,
                                                        bfie_pkg::mem_addr_type k);
      logic [bfie_pkg::MEM_AW:0] diff;
      if (a < k) begin
         diff = {1'b0, a} + DEPTH_W - {1'b0, k};
      end else begin
         diff = {1'b0, a} - {1'b0, k};
      end
      return diff[bfie_pkg::MEM_AW-1:0];
   endfunction

   logic [7:0] mem [bfie_pkg::MEM_DEPTH];

   // window: l/c/r hold dp-1, dp, dp+1; pl/pr hold dp-2, dp+2
   bfie_pkg::mem_addr_type dp_ff, dp_in;
   logic [7:0] l_ff, l_in, c_ff, c_in, r_ff, r_in;
   logic [7:0] pl_ff, pl_in, pr_ff, pr_in;
   logic       pl_mem_ff, pl_mem_in, pr_mem_ff, pr_mem_in;
   logic [7:0] rd_ff;
   logic       clr_busy_ff, clr_busy_in;
   bfie_pkg::mem_addr_type clr_addr_ff, clr_addr_in;

   logic       wr_en, rd_en;
   bfie_pkg::mem_addr_type wr_addr, rd_addr;
   logic [7:0] wr_data;
   logic [7:0] pl_val, pr_val;

   // an edge cell may still sit in the read register after a move
   assign pl_val = pl_mem_ff ? rd_ff : pl_ff;
   assign pr_val = pr_mem_ff ? rd_ff : pr_ff;

   always_comb begin
      dp_in       = dp_ff;
      l_in        = l_ff;
      c_in        = c_ff;
      r_in        = r_ff;
      pl_in       = pl_ff;
      pr_in       = pr_ff;
      pl_mem_in   = pl_mem_ff;
      pr_mem_in   = pr_mem_ff;
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_addr_ff;
      wr_data     = 8'd0;
      rd_en       = 1'b0;
      rd_addr     = dp_ff;
      if (clr_busy_ff) begin
         wr_en       = 1'b1;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end else if (op.move_up) begin
         dp_in     = addr_up(dp_ff, bfie_pkg::mem_addr_type'(1));
         l_in      = c_ff;
         c_in      = r_ff;
         r_in      = pr_val;
         pl_in     = l_ff;
         pl_mem_in = 1'b0;
         pr_mem_in = 1'b1;
         rd_en     = 1'b1;
         rd_addr   = addr_up(dp_ff, bfie_pkg::mem_addr_type'(3));
         wr_en     = 1'b1;
         wr_addr   = addr_down(dp_ff, bfie_pkg::mem_addr_type'(2));
         wr_data   = pl_val;
      end else if (op.move_down) begin
         dp_in     = addr_down(dp_ff, bfie_pkg::mem_addr_type'(1));
         r_in      = c_ff;
         c_in      = l_ff;
         l_in      = pl_val;
         pr_in     = r_ff;
         pr_mem_in = 1'b0;
         pl_mem_in = 1'b1;
         rd_en     = 1'b1;
         rd_addr   = addr_down(dp_ff, bfie_pkg::mem_addr_type'(3));
         wr_en     = 1'b1;
         wr_addr   = addr_up(dp_ff, bfie_pkg::mem_addr_type'(2));
         wr_data   = pr_val;
      end else if (op.write_en) begin
         c_in = op.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff       <= '0;
         l_ff        <= 8'd0;
         c_ff        <= 8'd0;
         r_ff        <= 8'd0;
         pl_ff       <= 8'd0;
         pr_ff       <= 8'd0;
         pl_mem_ff   <= 1'b0;
         pr_mem_ff   <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         dp_ff       <= dp_in;
         l_ff        <= l_in;
         c_ff        <= c_in;
         r_ff        <= r_in;
         pl_ff       <= pl_in;
         pr_ff       <= pr_in;
         pl_mem_ff   <= pl_mem_in;
         pr_mem_ff   <= pr_mem_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign cur_cell = c_ff;
   assign busy     = clr_busy_ff;

endmodule

// File: hdl/bfie_checker.sv
// port-level checks for the executor, bound to the top level
module bfie_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bfie_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bfie_pkg::rsp_type rsp_data
);

   logic        seen_ff;
   logic [31:0] last_step_ff;

   // step count of the last delivered response
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_step_ff <= 32'd0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff      <= 1'b1;
         last_step_ff <= rsp_data.step_count;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request changed while waiting");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request accepted before memory clear");

   a_out_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |-> rsp_data.out_byte == 8'd0)
      else $error("output byte set without output flag");

   a_step_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && seen_ff |-> rsp_data.step_count == last_step_ff + 32'd1)
      else $error("response lost or repeated");

endmodule

bind bf_instruction_executor_unit bfie_checker u_bfie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: sim/bf_instruction_executor_unit_tb.sv
// self-checking testbench for the tape-language executor: directed rows, then random programs
module bf_instruction_executor_unit_tb;

   localparam int RANDOM_ITEMS   = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct packed {
      bfie_pkg::req_type req;
      logic              typed;
      bfie_pkg::rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bfie_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bfie_pkg::rsp_type rsp_data;

   // predicted executor state
   logic [7:0]              tape_cells [bfie_pkg::MEM_DEPTH];
   bfie_pkg::mem_addr_type  tape_ptr   = '0;
   bfie_pkg::code_addr_type fetch_addr = '0;
   bfie_pkg::scan_dir_type  scan_dir   = bfie_pkg::SCAN_NONE;
   logic [11:0]             nest       = '0;
   logic [31:0]             step_total = '0;

   logic [7:0]        program_text [bfie_pkg::CODE_DEPTH];
   bfie_pkg::rsp_type result_q [$];
   bit                quiet = 1'b0;
   int                ready_hold  = 0;
   int                idle_cycles = 0;
   int                n_errors    = 0;
   int                n_requests  = 0;
   int                n_responses = 0;
   int                n_emitted   = 0;
   int                n_taken     = 0;
   int                n_scans     = 0;

   bf_instruction_executor_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in response %0d: %s is 0x%0h, expected 0x%0h",
               n_responses, what, got, want);
      n_errors++;
   endtask

   task automatic execute_symbol(input bfie_pkg::req_type r, output bfie_pkg::rsp_type res);
      bfie_pkg::mem_addr_type ptr;
      logic [7:0]             own_kind;
      logic [7:0]             other_kind;
      res = '0;
      ptr = tape_ptr;
      step_total = step_total + 32'd1;
      if (scan_dir == bfie_pkg::SCAN_LEFT || scan_dir == bfie_pkg::SCAN_RIGHT) begin
         // only brackets matter while scanning: own kind nests, other kind unnests or closes
         own_kind   = (scan_dir == bfie_pkg::SCAN_LEFT) ? bfie_pkg::SYM_BACK : bfie_pkg::SYM_LOOP;
         other_kind = (scan_dir == bfie_pkg::SCAN_LEFT) ? bfie_pkg::SYM_LOOP : bfie_pkg::SYM_BACK;
         if (r.symbol == own_kind) begin
            nest = nest + 12'd1;
         end else if (r.symbol == other_kind) begin
            if (nest == 12'd0) scan_dir = bfie_pkg::SCAN_NONE;
            else nest = nest - 12'd1;
         end
      end else begin
         case (r.symbol)
            bfie_pkg::SYM_INC:  tape_cells[ptr] = tape_cells[ptr] + 8'd1;
            bfie_pkg::SYM_DEC:  tape_cells[ptr] = tape_cells[ptr] - 8'd1;
            bfie_pkg::SYM_NEXT: ptr = ptr + 1'b1;
            bfie_pkg::SYM_PREV: ptr = ptr - 1'b1;
            bfie_pkg::SYM_OUT: begin
               res.out_valid = 1'b1;
               res.out_byte  = tape_cells[ptr];
               n_emitted++;
            end
            bfie_pkg::SYM_IN: begin
               tape_cells[ptr] = r.in_byte;
               res.in_taken    = 1'b1;
               n_taken++;
            end
            bfie_pkg::SYM_BACK:
               if (tape_cells[ptr] != 8'd0) scan_dir = bfie_pkg::SCAN_LEFT;
            bfie_pkg::SYM_LOOP:
               if (tape_cells[ptr] == 8'd0) scan_dir = bfie_pkg::SCAN_RIGHT;
            default: ;
         endcase
         tape_ptr = ptr;
         if (scan_dir != bfie_pkg::SCAN_NONE) n_scans++;
      end
      fetch_addr = (scan_dir == bfie_pkg::SCAN_LEFT) ? fetch_addr - 1'b1 : fetch_addr + 1'b1;
      res.next_code_addr = 12'(fetch_addr);
      res.step_count     = step_total;
   endtask

   task automatic send_request(input bfie_pkg::req_type r, input logic typed,
                               input bfie_pkg::rsp_type want);
      bfie_pkg::rsp_type predicted;
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      execute_symbol(r, predicted);
      result_q.push_back(typed ? want : predicted);
      n_requests++;
   endtask

   function automatic logic [7:0] random_body_symbol();
      case ($urandom_range(0, 6))
         0, 1:    return bfie_pkg::SYM_INC;
         2:       return bfie_pkg::SYM_DEC;
         3:       return bfie_pkg::SYM_NEXT;
         4:       return bfie_pkg::SYM_PREV;
         5:       return bfie_pkg::SYM_OUT;
         default: return bfie_pkg::SYM_IN;
      endcase
   endfunction

   always @(posedge clock) begin : rsp_side
      bfie_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_responses++;
            if (result_q.size() == 0) begin
               report_mismatch("unexpected response, step_count", rsp_data.step_count, '0);
            end else begin
               want = result_q.pop_front();
               if (rsp_data.next_code_addr != want.next_code_addr)
                  report_mismatch("next_code_addr", 32'(rsp_data.next_code_addr),
                                  32'(want.next_code_addr));
               if (rsp_data.out_valid != want.out_valid)
                  report_mismatch("out_valid", 32'(rsp_data.out_valid), 32'(want.out_valid));
               if (rsp_data.out_byte != want.out_byte)
                  report_mismatch("out_byte", 32'(rsp_data.out_byte), 32'(want.out_byte));
               if (rsp_data.in_taken != want.in_taken)
                  report_mismatch("in_taken", 32'(rsp_data.in_taken), 32'(want.in_taken));
               if (rsp_data.step_count != want.step_count)
                  report_mismatch("step_count", rsp_data.step_count, want.step_count);
            end
            ready_hold = quiet ? 0 : $urandom_range(0, 8);
         end else if (ready_hold != 0) begin
            ready_hold--;
         end
         rsp_ready <= (ready_hold == 0);
      end
   end

   // covers the clearing pass after reset with plenty of margin
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, result_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_row_type            stim_rows [$];
      bfie_pkg::req_type       r;
      bfie_pkg::code_addr_type a;
      logic [7:0]              junk;
      int                      phase_len;
      int                      open_cnt;
      int                      n_random;
      foreach (tape_cells[i]) tape_cells[i] = 8'd0;
      stim_rows = '{
         // first symbol after reset, input extremes, scan left across address zero
         '{'{bfie_pkg::SYM_OUT,  8'h00}, 1'b1, '{12'd1,    1'b1, 8'h00, 1'b0, 32'd1}},
         '{'{bfie_pkg::SYM_IN,   8'hFF}, 1'b1, '{12'd2,    1'b0, 8'h00, 1'b1, 32'd2}},
         '{'{bfie_pkg::SYM_BACK, 8'h00}, 1'b1, '{12'd1,    1'b0, 8'h00, 1'b0, 32'd3}},
         '{'{8'h00,              8'h00}, 1'b1, '{12'd0,    1'b0, 8'h00, 1'b0, 32'd4}},
         '{'{8'hFF,              8'hFF}, 1'b1, '{12'd4095, 1'b0, 8'h00, 1'b0, 32'd5}},
         '{'{bfie_pkg::SYM_LOOP, 8'h00}, 1'b1, '{12'd0,    1'b0, 8'h00, 1'b0, 32'd6}},
         '{'{bfie_pkg::SYM_OUT,  8'h00}, 1'b1, '{12'd1,    1'b1, 8'hFF, 1'b0, 32'd7}},
         // cell wrap both ways, data pointer wrap both ways
         '{'{bfie_pkg::SYM_INC,  8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_DEC,  8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_PREV, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_OUT,  8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_IN,   8'h80}, 1'b0, '0},
         '{'{bfie_pkg::SYM_NEXT, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_OUT,  8'h00}, 1'b0, '0},
         // open bracket on a nonzero cell, then a nested scan right
         '{'{bfie_pkg::SYM_LOOP, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_IN,   8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_LOOP, 8'h5A}, 1'b0, '0},
         '{'{bfie_pkg::SYM_LOOP, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_INC,  8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_BACK, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_BACK, 8'h00}, 1'b0, '0},
         // nested scan left from the wrapped pointer
         '{'{bfie_pkg::SYM_PREV, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_BACK, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_BACK, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_LOOP, 8'h00}, 1'b0, '0},
         '{'{bfie_pkg::SYM_LOOP, 8'h00}, 1'b0, '0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);

      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         // bracket-free filler so scans only match inside the loop body below
         foreach (program_text[i]) begin
            junk = 8'($urandom());
            if (junk == bfie_pkg::SYM_LOOP || junk == bfie_pkg::SYM_BACK)
               junk = bfie_pkg::SYM_INC;
            program_text[i] = ($urandom_range(0, 3) == 0) ? junk : random_body_symbol();
         end
         // balanced program starting at the current fetch address
         a         = fetch_addr;
         open_cnt  = 0;
         phase_len = $urandom_range(16, 60);
         for (int k = 0; k < phase_len || open_cnt > 0; k++) begin
            if (k >= phase_len) begin
               program_text[a] = bfie_pkg::SYM_BACK;
               open_cnt--;
            end else begin
               case ($urandom_range(0, 9))
                  0: begin
                     program_text[a] = bfie_pkg::SYM_LOOP;
                     open_cnt++;
                  end
                  1: if (open_cnt > 0) begin
                     program_text[a] = bfie_pkg::SYM_BACK;
                     open_cnt--;
                  end
                  default: program_text[a] = random_body_symbol();
               endcase
            end
            a = a + 1'b1;
         end

         phase_len = $urandom_range(40, 90);
         for (int k = 0; k < phase_len; k++) begin
            r.symbol  = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : program_text[fetch_addr];
            r.in_byte = 8'($urandom());
            send_request(r, 1'b0, '0);
         end
         n_random += phase_len;
         // a stray bracket may leave a scan open; close it by hand
         while (scan_dir != bfie_pkg::SCAN_NONE) begin
            r.symbol  = (scan_dir == bfie_pkg::SCAN_LEFT) ? bfie_pkg::SYM_LOOP
                                                          : bfie_pkg::SYM_BACK;
            r.in_byte = 8'($urandom());
            send_request(r, 1'b0, '0);
            n_random++;
         end
         req_valid <= 1'b0;
         while (result_q.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d directed and %0d random requests, %0d responses checked",
               stim_rows.size(), n_random, n_responses);
      $display("program activity: %0d bytes out, %0d bytes in, %0d bracket scans",
               n_emitted, n_taken, n_scans);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
